@@ hdl/rsm_pkg.sv @@
package rsm_pkg;

  // Default sizes of the stores.
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned PROG_DEPTH_DEF  = 1024;
  localparam int unsigned VAR_COUNT_DEF   = 256;

  // Width of the program length register.
  localparam int unsigned PLEN_W = 11;

  // Iterations of the shared divider, one quotient bit each.
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [4:0] {
    OP_PUSHINT   = 5'd0,
    OP_PUSHLABEL = 5'd1,
    OP_PUSHVAR   = 5'd2,
    OP_GO        = 5'd3,
    OP_GOFALSE   = 5'd4,
    OP_CLEAR     = 5'd5,
    OP_VARVAL    = 5'd6,
    OP_OR        = 5'd7,
    OP_AND       = 5'd8,
    OP_EQ        = 5'd9,
    OP_NE        = 5'd10,
    OP_LT        = 5'd11,
    OP_LE        = 5'd12,
    OP_GT        = 5'd13,
    OP_GE        = 5'd14,
    OP_ADD       = 5'd15,
    OP_SUB       = 5'd16,
    OP_MUL       = 5'd17,
    OP_DIV       = 5'd18,
    OP_MOD       = 5'd19,
    OP_NOT       = 5'd20,
    OP_NEGATE    = 5'd21,
    OP_PREINC    = 5'd22,
    OP_PREDEC    = 5'd23,
    OP_POSTINC   = 5'd24,
    OP_POSTDEC   = 5'd25,
    OP_ASSIGN    = 5'd26,
    OP_RESTART   = 5'd27
  } opcode_e;

  typedef enum logic [3:0] {
    ERR_OK         = 4'd0,
    ERR_UNDERFLOW  = 4'd1,
    ERR_OVERFLOW   = 4'd2,
    ERR_NOTINT     = 4'd3,
    ERR_NOTLABEL   = 4'd4,
    ERR_NOTVAR     = 4'd5,
    ERR_UNDECLARED = 4'd6,
    ERR_UNDEFINED  = 4'd7,
    ERR_JUMP       = 4'd8,
    ERR_DIV0       = 4'd9,
    ERR_PASTEND    = 4'd10,
    ERR_HALTED     = 4'd11
  } err_e;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_LABEL = 2'd1,
    KIND_VAR   = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_WRITE,
    ST_FILL,
    ST_FILLW,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        next_command;
    logic signed [31:0] top_value;
    logic [1:0]         top_kind;
    logic [6:0]         stack_depth;
    logic [3:0]         error_code;
    logic               ended;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } stk_entry_t;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_req_t;

endpackage

@@ hdl/rpn_stack_machine_step.sv @@
// Each instruction passes through the states READ, EXEC and OUT for most opcodes;
// if-false jumps add FILL and FILLW, as the new top is fetched from the stack RAM again.
// Divide and modulo add DIV and WRITE, DIV waiting on the 32-step iterative divider.
// One instruction is worked on at a time; the next is taken once the result is registered.
// Reset clears the stack pointer, command counter, halt flag, program length and all
// variable defined bits; the stack and variable RAMs are not cleared.
module rpn_stack_machine_step #(
  parameter int unsigned STACK_DEPTH = rsm_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PROG_DEPTH  = rsm_pkg::PROG_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = rsm_pkg::VAR_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  rsm_pkg::in_item_t        in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output rsm_pkg::out_item_t       out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [rsm_pkg::PLEN_W-1:0] cfg_data_i
);
  import rsm_pkg::*;

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SA_W  = $clog2(STACK_DEPTH);
  localparam int unsigned CC_W  = $clog2(PROG_DEPTH + 1);
  localparam int unsigned LEN_W = (CC_W > PLEN_W) ? CC_W : PLEN_W;
  localparam int unsigned VAR_W = $clog2(VAR_COUNT);

  state_e              state_q, state_d;
  in_item_t            item_q;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [CC_W-1:0]     cc_q, cc_d;
  logic [31:0]         top_val_q, top_val_d;
  logic [1:0]          top_kind_q, top_kind_d;
  logic                halted_q;
  logic [PLEN_W-1:0]   plen_q;
  err_e                err_q;
  logic [VAR_COUNT-1:0] defined_q;
  out_item_t           out_q;
  logic                out_valid_q;

  stk_entry_t          stk_mem [STACK_DEPTH];
  stk_entry_t          stk_rd_q;
  logic [31:0]         var_mem [VAR_COUNT];
  logic [31:0]         var_rd_q;

  opcode_e             op;
  logic [31:0]         t;
  logic [31:0]         u;
  logic [1:0]          tk;
  logic [1:0]          uk;
  logic [SP_W-1:0]     sp_m1;
  logic [SP_W-1:0]     sp_m2;
  logic [SA_W-1:0]     rd_addr;
  logic [LEN_W-1:0]    eff_len;
  logic                jump_bad;
  logic                t_idx_bad;
  logic                u_idx_bad;
  logic [31:0]         alu_res;
  logic [31:0]         div_res;
  logic                div_done;
  div_req_t            div_req;
  logic [31:0]         bin_res;
  logic [31:0]         var_new;
  logic [31:0]         var_res;

  err_e                err;
  logic                commit;
  logic                div_go;
  logic                fill_go;
  logic                stk_we;
  logic [SA_W-1:0]     stk_waddr;
  stk_entry_t          stk_wdata;
  logic                var_we;
  logic [VAR_W-1:0]    var_waddr;
  logic [31:0]         var_wdata;
  logic                def_set;
  logic                out_load;

  // Operands: the cached top and the entry below it read from the stack RAM.
  assign op    = opcode_e'(item_q.opcode);
  assign t     = top_val_q;
  assign tk    = top_kind_q;
  assign u     = stk_rd_q.value;
  assign uk    = stk_rd_q.kind;
  assign sp_m1 = sp_q - SP_W'(1);
  assign sp_m2 = sp_q - SP_W'(2);

  // Effective program length saturates at the program store size.
  assign eff_len = (LEN_W'(plen_q) > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH)
                                                         : LEN_W'(plen_q);

  // Range checks for jump targets and variable indices.
  assign jump_bad  = t[31] || (t > 32'(eff_len));
  assign t_idx_bad = t[31] || (t >= 32'(VAR_COUNT));
  assign u_idx_bad = u[31] || (u >= 32'(VAR_COUNT));

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= '0;
    end else if (cfg_valid_i) begin
      plen_q <= cfg_data_i;
    end
  end

  rsm_alu u_alu (
    .op_i     (op),
    .a_i      (u),
    .b_i      (t),
    .result_o (alu_res)
  );

  rsm_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (div_req),
    .a_i      (u),
    .b_i      (t),
    .done_o   (div_done),
    .result_o (div_res)
  );

  assign div_req.start  = div_go;
  assign div_req.is_mod = (op == OP_MOD);
  assign bin_res = ((op == OP_DIV) || (op == OP_MOD)) ? div_res : alu_res;

  // Variable update for the increment and decrement opcodes.
  always_comb begin
    case (op)
      OP_PREINC, OP_POSTINC: var_new = var_rd_q + 32'd1;
      OP_PREDEC, OP_POSTDEC: var_new = var_rd_q - 32'd1;
      default:               var_new = var_rd_q;
    endcase
    var_res = ((op == OP_PREINC) || (op == OP_PREDEC)) ? var_new : var_rd_q;
  end

  // Stack RAM: the read address is the entry below the top, or the new top on a refill.
  assign rd_addr = (state_q == ST_FILL) ? sp_m1[SA_W-1:0] : sp_m2[SA_W-1:0];

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[rd_addr];
  end

  // Variable RAM, read at the top value; ASSIGN writes at the entry below it.
  always_ff @(posedge clk_i) begin
    if (var_we) begin
      var_mem[var_waddr] <= var_wdata;
    end
    var_rd_q <= var_mem[t[VAR_W-1:0]];
  end

  // Instruction decode: checks, stack and variable effects and the error code.
  always_comb begin
    err        = ERR_OK;
    div_go     = 1'b0;
    fill_go    = 1'b0;
    sp_d       = sp_q;
    cc_d       = cc_q;
    top_val_d  = top_val_q;
    top_kind_d = top_kind_q;
    stk_we     = 1'b0;
    stk_waddr  = sp_m1[SA_W-1:0];
    stk_wdata  = '{kind: KIND_INT, value: bin_res};
    var_we     = 1'b0;
    var_waddr  = t[VAR_W-1:0];
    var_wdata  = var_new;
    def_set    = 1'b0;
    if (op == OP_RESTART) begin
      sp_d = '0;
      cc_d = '0;
    end else if (halted_q) begin
      err = ERR_HALTED;
    end else if (LEN_W'(cc_q) >= eff_len) begin
      err = ERR_PASTEND;
    end else begin
      case (op)
        OP_PUSHINT, OP_PUSHLABEL, OP_PUSHVAR: begin
          if (sp_q >= SP_W'(STACK_DEPTH)) begin
            err = ERR_OVERFLOW;
          end else begin
            stk_we     = 1'b1;
            stk_waddr  = sp_q[SA_W-1:0];
            stk_wdata  = '{kind: item_q.opcode[1:0], value: item_q.immediate};
            top_val_d  = item_q.immediate;
            top_kind_d = item_q.opcode[1:0];
            sp_d       = sp_q + SP_W'(1);
            cc_d       = cc_q + CC_W'(1);
          end
        end
        OP_GO: begin
          if (sp_q == '0) begin
            err = ERR_UNDERFLOW;
          end else if (tk != KIND_LABEL) begin
            err = ERR_NOTLABEL;
          end else if (jump_bad) begin
            err = ERR_JUMP;
          end else begin
            cc_d       = t[CC_W-1:0];
            sp_d       = sp_m1;
            top_val_d  = u;
            top_kind_d = uk;
          end
        end
        OP_GOFALSE: begin
          if (sp_q < SP_W'(2)) begin
            err = ERR_UNDERFLOW;
          end else if (uk != KIND_INT) begin
            err = ERR_NOTINT;
          end else if (tk != KIND_LABEL) begin
            err = ERR_NOTLABEL;
          end else if ((u == 32'd0) && jump_bad) begin
            err = ERR_JUMP;
          end else begin
            cc_d    = (u == 32'd0) ? t[CC_W-1:0] : cc_q + CC_W'(1);
            sp_d    = sp_m2;
            fill_go = 1'b1;
          end
        end
        OP_CLEAR: begin
          if (sp_q != '0) begin
            sp_d       = sp_m1;
            top_val_d  = u;
            top_kind_d = uk;
          end
          cc_d = cc_q + CC_W'(1);
        end
        OP_VARVAL, OP_PREINC, OP_PREDEC, OP_POSTINC, OP_POSTDEC: begin
          if (sp_q == '0) begin
            err = ERR_UNDERFLOW;
          end else if (tk != KIND_VAR) begin
            err = ERR_NOTVAR;
          end else if (t_idx_bad) begin
            err = ERR_UNDECLARED;
          end else if (!defined_q[t[VAR_W-1:0]]) begin
            err = ERR_UNDEFINED;
          end else begin
            var_we     = (op != OP_VARVAL);
            stk_we     = 1'b1;
            stk_wdata  = '{kind: KIND_INT, value: var_res};
            top_val_d  = var_res;
            top_kind_d = KIND_INT;
            cc_d       = cc_q + CC_W'(1);
          end
        end
        OP_NOT, OP_NEGATE: begin
          if (sp_q == '0) begin
            err = ERR_UNDERFLOW;
          end else if (tk != KIND_INT) begin
            err = ERR_NOTINT;
          end else begin
            stk_we    = 1'b1;
            stk_wdata = '{kind: KIND_INT, value: alu_res};
            top_val_d = alu_res;
            cc_d      = cc_q + CC_W'(1);
          end
        end
        OP_ASSIGN: begin
          if (sp_q < SP_W'(2)) begin
            err = ERR_UNDERFLOW;
          end else if (uk != KIND_VAR) begin
            err = ERR_NOTVAR;
          end else if (tk != KIND_INT) begin
            err = ERR_NOTINT;
          end else if (u_idx_bad) begin
            err = ERR_UNDECLARED;
          end else begin
            var_we     = 1'b1;
            var_waddr  = u[VAR_W-1:0];
            var_wdata  = t;
            def_set    = 1'b1;
            stk_we     = 1'b1;
            stk_waddr  = sp_m2[SA_W-1:0];
            stk_wdata  = '{kind: KIND_INT, value: t};
            top_val_d  = t;
            top_kind_d = KIND_INT;
            sp_d       = sp_m1;
            cc_d       = cc_q + CC_W'(1);
          end
        end
        OP_OR, OP_AND, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
          if (sp_q < SP_W'(2)) begin
            err = ERR_UNDERFLOW;
          end else if ((uk != KIND_INT) || (tk != KIND_INT)) begin
            err = ERR_NOTINT;
          end else if (((op == OP_DIV) || (op == OP_MOD)) && (t == 32'd0)) begin
            err = ERR_DIV0;
          end else if (((op == OP_DIV) || (op == OP_MOD)) && (state_q == ST_EXEC)) begin
            div_go = 1'b1;
          end else begin
            stk_we     = 1'b1;
            stk_waddr  = sp_m2[SA_W-1:0];
            stk_wdata  = '{kind: KIND_INT, value: bin_res};
            top_val_d  = bin_res;
            top_kind_d = KIND_INT;
            sp_d       = sp_m1;
            cc_d       = cc_q + CC_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
    // Nothing is written outside the commit cycle.
    commit = ((state_q == ST_EXEC) && !div_go) || (state_q == ST_WRITE);
    if (!commit) begin
      stk_we  = 1'b0;
      var_we  = 1'b0;
      def_set = 1'b0;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC: begin
        if (div_go) begin
          state_d = ST_DIV;
        end else if (fill_go) begin
          state_d = ST_FILL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV:   if (div_done) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_OUT;
      ST_FILL:  state_d = ST_FILLW;
      ST_FILLW: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      sp_q      <= '0;
      cc_q      <= '0;
      halted_q  <= 1'b0;
      defined_q <= '0;
      err_q     <= ERR_OK;
    end else begin
      state_q <= state_d;
      if (commit) begin
        sp_q  <= sp_d;
        cc_q  <= cc_d;
        err_q <= err;
        if (op == OP_RESTART) begin
          halted_q <= 1'b0;
        end else if ((err != ERR_OK) && (err != ERR_HALTED)) begin
          halted_q <= 1'b1;
        end
      end
      if (def_set) begin
        defined_q[var_waddr] <= 1'b1;
      end
    end
  end

  // Instruction and cached top of stack.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (commit) begin
      top_val_q  <= top_val_d;
      top_kind_q <= top_kind_d;
    end else if (state_q == ST_FILLW) begin
      top_val_q  <= stk_rd_q.value;
      top_kind_q <= stk_rd_q.kind;
    end
  end

  // Result register towards the output channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.next_command <= 11'(LEN_W'(cc_q));
      out_q.top_value    <= (sp_q != '0) ? top_val_q : 32'd0;
      out_q.top_kind     <= (sp_q != '0) ? top_kind_q : KIND_EMPTY;
      out_q.stack_depth  <= 7'(sp_q);
      out_q.error_code   <= err_q;
      out_q.ended        <= (LEN_W'(cc_q) >= eff_len);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/rsm_alu.sv @@
module rsm_alu (
  input  rsm_pkg::opcode_e op_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  output logic [31:0]      result_o
);
  import rsm_pkg::*;

  logic a_lt_b;
  logic b_lt_a;

  // Signed orderings of the two operands.
  assign a_lt_b = $signed(a_i) < $signed(b_i);
  assign b_lt_a = $signed(b_i) < $signed(a_i);

  // Combinational operations; the unary ones work on the top operand.
  always_comb begin
    case (op_i)
      OP_OR:     result_o = {31'd0, (a_i != 32'd0) || (b_i != 32'd0)};
      OP_AND:    result_o = {31'd0, (a_i != 32'd0) && (b_i != 32'd0)};
      OP_EQ:     result_o = {31'd0, a_i == b_i};
      OP_NE:     result_o = {31'd0, a_i != b_i};
      OP_LT:     result_o = {31'd0, a_lt_b};
      OP_LE:     result_o = {31'd0, !b_lt_a};
      OP_GT:     result_o = {31'd0, b_lt_a};
      OP_GE:     result_o = {31'd0, !a_lt_b};
      OP_ADD:    result_o = a_i + b_i;
      OP_SUB:    result_o = a_i - b_i;
      OP_MUL:    result_o = a_i * b_i;
      OP_NOT:    result_o = {31'd0, b_i == 32'd0};
      OP_NEGATE: result_o = 32'd0 - b_i;
      default:   result_o = 32'd0;
    endcase
  end

endmodule

@@ hdl/rsm_divider.sv @@
module rsm_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsm_pkg::div_req_t req_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output logic              done_o,
  output logic [31:0]       result_o
);
  import rsm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [31:0]      rem_q;
  logic [31:0]      quo_q;
  logic [31:0]      dvs_q;
  logic             neg_q;
  logic             mod_q;
  logic [32:0]      rem_sh;
  logic [32:0]      diff;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers, working on magnitudes.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= a_i[31] ? 32'd0 - a_i : a_i;
      dvs_q <= b_i[31] ? 32'd0 - b_i : b_i;
      rem_q <= 32'd0;
      mod_q <= req_i.is_mod;
      neg_q <= req_i.is_mod ? a_i[31] : (a_i[31] ^ b_i[31]);
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  // Signs are restored at the end; the remainder takes the dividend's sign.
  always_comb begin
    if (mod_q) begin
      result_o = neg_q ? 32'd0 - rem_q : rem_q;
    end else begin
      result_o = neg_q ? 32'd0 - quo_q : quo_q;
    end
  end

  assign done_o = done_q;

endmodule

@@ hdl/rsm_checker.sv @@
module rsm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rsm_pkg::out_item_t out_data_o
);
  import rsm_pkg::*;

  // Only one instruction is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("instruction accepted while another is in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // An empty stack shows a zero value of the empty kind.
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.stack_depth == 7'd0)) |->
      ((out_data_o.top_kind == KIND_EMPTY) && (out_data_o.top_value == 32'sd0)))
    else $error("empty stack reported with a top entry");

  // A non-empty stack never shows the empty kind.
  a_full_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.stack_depth != 7'd0)) |->
      (out_data_o.top_kind != KIND_EMPTY))
    else $error("occupied stack reported as empty");

endmodule

bind rpn_stack_machine_step rsm_checker u_rsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ tb/sv/rpn_stack_machine_step_tb.sv @@
module rpn_stack_machine_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsm_pkg::*;

  localparam int unsigned STK_N = 64;
  localparam int unsigned PROG_N = 1024;
  localparam int unsigned VAR_N = 256;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  // Predicts each step of the machine and checks the results in order.
  class rpn_scoreboard;
    logic [31:0] stk_val [STK_N];
    logic [1:0]  stk_kind [STK_N];
    int unsigned depth;
    int unsigned cmd_ctr;
    logic [31:0] var_val [VAR_N];
    bit          var_def [VAR_N];
    bit          halt_flag;
    int unsigned prog_len;
    out_item_t   pending [$];
    int unsigned err_count;

    function new();
      depth = 0;
      cmd_ctr = 0;
      halt_flag = 0;
      prog_len = 0;
      err_count = 0;
      foreach (var_def[i]) var_def[i] = 0;
    endfunction

    function void set_length(logic [10:0] v);
      prog_len = v;
    endfunction

    function int unsigned eff_len();
      return (prog_len > PROG_N) ? PROG_N : prog_len;
    endfunction

    function err_e jump_to(logic [31:0] tgt);
      if (tgt[31] || tgt > eff_len()) return ERR_JUMP;
      cmd_ctr = tgt;
      return ERR_OK;
    endfunction

    function err_e var_slot(logic [31:0] v, output int unsigned idx);
      idx = 0;
      if (v[31] || v >= VAR_N) return ERR_UNDECLARED;
      idx = v;
      return ERR_OK;
    endfunction

    // Binary arithmetic and compare; a is the lower entry, b the top.
    function err_e binary(opcode_e op, logic [31:0] a, logic [31:0] b,
                          output logic [31:0] r);
      logic signed [31:0] sa, sb;
      logic [31:0] ma, mb, q;
      sa = a;
      sb = b;
      r = '0;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      case (op)
        OP_OR: r = (a != 0 || b != 0);
        OP_AND: r = (a != 0 && b != 0);
        OP_EQ: r = (a == b);
        OP_NE: r = (a != b);
        OP_LT: r = (sa < sb);
        OP_LE: r = (sa <= sb);
        OP_GT: r = (sa > sb);
        OP_GE: r = (sa >= sb);
        OP_ADD: r = a + b;
        OP_SUB: r = a - b;
        OP_MUL: r = a * b;
        OP_DIV: begin
          if (b == 0) return ERR_DIV0;
          q = ma / mb;
          r = (a[31] ^ b[31]) ? -q : q;
        end
        default: begin
          if (b == 0) return ERR_DIV0;
          q = ma % mb;
          r = a[31] ? -q : q;
        end
      endcase
      return ERR_OK;
    endfunction

    function err_e execute(opcode_e op, logic [31:0] imm);
      logic [31:0] t, u, r;
      logic [1:0] tk, uk;
      int unsigned idx;
      err_e e;
      t = 0; u = 0; tk = 0; uk = 0; r = 0;
      if (depth >= 1) begin
        t = stk_val[depth-1]; tk = stk_kind[depth-1];
      end
      if (depth >= 2) begin
        u = stk_val[depth-2]; uk = stk_kind[depth-2];
      end
      case (op)
        OP_PUSHINT, OP_PUSHLABEL, OP_PUSHVAR: begin
          if (depth >= STK_N) return ERR_OVERFLOW;
          stk_val[depth] = imm;
          stk_kind[depth] = op[1:0];
          depth++;
          cmd_ctr++;
        end
        OP_GO: begin
          if (depth < 1) return ERR_UNDERFLOW;
          if (tk != KIND_LABEL) return ERR_NOTLABEL;
          e = jump_to(t);
          if (e != ERR_OK) return e;
          depth--;
        end
        OP_GOFALSE: begin
          if (depth < 2) return ERR_UNDERFLOW;
          if (uk != KIND_INT) return ERR_NOTINT;
          if (tk != KIND_LABEL) return ERR_NOTLABEL;
          if (u == 0) begin
            e = jump_to(t);
            if (e != ERR_OK) return e;
          end else cmd_ctr++;
          depth -= 2;
        end
        OP_CLEAR: begin
          if (depth >= 1) depth--;
          cmd_ctr++;
        end
        OP_VARVAL, OP_PREINC, OP_PREDEC, OP_POSTINC, OP_POSTDEC: begin
          if (depth < 1) return ERR_UNDERFLOW;
          if (tk != KIND_VAR) return ERR_NOTVAR;
          e = var_slot(t, idx);
          if (e != ERR_OK) return e;
          if (!var_def[idx]) return ERR_UNDEFINED;
          r = var_val[idx];
          case (op)
            OP_PREINC: begin var_val[idx] = r + 1; r = r + 1; end
            OP_PREDEC: begin var_val[idx] = r - 1; r = r - 1; end
            OP_POSTINC: var_val[idx] = r + 1;
            OP_POSTDEC: var_val[idx] = r - 1;
            default: ;
          endcase
          stk_val[depth-1] = r;
          stk_kind[depth-1] = KIND_INT;
          cmd_ctr++;
        end
        OP_NOT, OP_NEGATE: begin
          if (depth < 1) return ERR_UNDERFLOW;
          if (tk != KIND_INT) return ERR_NOTINT;
          stk_val[depth-1] = (op == OP_NOT) ? 32'(t == 0) : -t;
          cmd_ctr++;
        end
        OP_ASSIGN: begin
          if (depth < 2) return ERR_UNDERFLOW;
          if (uk != KIND_VAR) return ERR_NOTVAR;
          if (tk != KIND_INT) return ERR_NOTINT;
          e = var_slot(u, idx);
          if (e != ERR_OK) return e;
          var_val[idx] = t;
          var_def[idx] = 1;
          stk_val[depth-2] = t;
          stk_kind[depth-2] = KIND_INT;
          depth--;
          cmd_ctr++;
        end
        default: begin
          if (op >= OP_OR && op <= OP_MOD) begin
            if (depth < 2) return ERR_UNDERFLOW;
            if (uk != KIND_INT || tk != KIND_INT) return ERR_NOTINT;
            e = binary(op, u, t, r);
            if (e != ERR_OK) return e;
            stk_val[depth-2] = r;
            stk_kind[depth-2] = KIND_INT;
            depth--;
            cmd_ctr++;
          end
        end
      endcase
      return ERR_OK;
    endfunction

    // Notes an accepted instruction and queues the result it must give.
    function void note_instruction(in_item_t it);
      out_item_t res;
      err_e e;
      opcode_e op;
      op = opcode_e'(it.opcode);
      e = ERR_OK;
      if (op == OP_RESTART) begin
        halt_flag = 0;
        depth = 0;
        cmd_ctr = 0;
      end else if (halt_flag) e = ERR_HALTED;
      else if (cmd_ctr >= eff_len()) e = ERR_PASTEND;
      else e = execute(op, it.immediate);
      if (e != ERR_OK && e != ERR_HALTED) halt_flag = 1;
      res.next_command = cmd_ctr[10:0];
      res.top_value = (depth >= 1) ? stk_val[depth-1] : '0;
      res.top_kind = (depth >= 1) ? stk_kind[depth-1] : KIND_EMPTY;
      res.stack_depth = depth[6:0];
      res.error_code = e;
      res.ended = (cmd_ctr >= eff_len());
      pending.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      err_count++;
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
    endtask

    // Compares one accepted result with the oldest expectation.
    task check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        report("unexpected result", got.next_command, 0);
        return;
      end
      w = pending.pop_front();
      if (got.next_command !== w.next_command)
        report("next_command", got.next_command, w.next_command);
      if (got.top_value !== w.top_value) report("top_value", got.top_value, w.top_value);
      if (got.top_kind !== w.top_kind) report("top_kind", got.top_kind, w.top_kind);
      if (got.stack_depth !== w.stack_depth)
        report("stack_depth", got.stack_depth, w.stack_depth);
      if (got.error_code !== w.error_code)
        report("error_code", got.error_code, w.error_code);
      if (got.ended !== w.ended) report("ended", got.ended, w.ended);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [PLEN_W-1:0] cfg_data = '0;

  rpn_scoreboard sb = new();
  longint unsigned cycle_count = 0;
  bit hold_off = 0;

  rpn_stack_machine_step dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Each result transaction is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall pattern, with an occasional long hold-off.
  initial begin
    int unsigned n;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1;
      end else begin
        n = gap_len();
        if (n == 0 || $urandom_range(0, 3) == 0) out_stall <= 0;
        else begin
          out_stall <= 1;
          repeat (n) @(negedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // Offers one instruction; valid stays high when the next one follows at once.
  task automatic send(opcode_e op, logic [31:0] imm);
    int unsigned n;
    n = gap_len();
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) begin
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= {op, imm};
    do @(posedge clk); while (in_stall);
    sb.note_instruction({op, imm});
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_length(logic [10:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  // A variable index, mostly in 0..7 but sometimes negative or out of range;
  // reads of unwritten variables are predicted as undefined-variable errors.
  function automatic logic [31:0] rand_index();
    case ($urandom_range(0, 9))
      0: return 32'hffff_ffff;
      1: return $urandom;
      2: return VAR_N;
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  task automatic random_instr();
    int unsigned p;
    opcode_e op;
    p = $urandom_range(0, 99);
    if (sb.halt_flag && $urandom_range(0, 2) != 0) send(OP_RESTART, $urandom);
    else if (sb.cmd_ctr + 2 >= sb.eff_len() && $urandom_range(0, 1) == 0)
      send(OP_RESTART, $urandom);
    else if (p < 25) send(OP_PUSHINT, rand_word());
    else if (p < 33) send(OP_PUSHVAR, rand_index());
    else if (p < 38)
      send(OP_PUSHLABEL, ($urandom_range(0, 9) == 0) ? rand_word()
                         : 32'($urandom_range(0, sb.eff_len())));
    else if (p < 40) begin
      send(opcode_e'($urandom_range(28, 31)), $urandom);
    end else if (p < 44) send(OP_ASSIGN, $urandom);
    else begin
      op = opcode_e'($urandom_range(OP_GO, OP_POSTDEC));
      send(op, $urandom);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: the extremes and the special cases.
    send(OP_PUSHINT, 0);               // past end with zero length
    send(OP_PUSHINT, 0);               // halted
    send(OP_RESTART, 0);
    write_length(11'h7ff);             // saturates at program depth
    send(OP_PUSHINT, 32'h8000_0000);
    send(OP_PUSHINT, 32'hffff_ffff);
    send(OP_DIV, 0);                   // division overflow
    send(OP_PUSHINT, 32'h8000_0000);
    send(OP_PUSHINT, 32'hffff_ffff);
    send(OP_MOD, 0);
    send(OP_PUSHINT, 0);
    send(OP_DIV, 0);                   // divide by zero
    send(OP_RESTART, 0);
    send(OP_PUSHVAR, 32'hffff_ffff);
    send(OP_PUSHINT, 32'h7fff_ffff);
    send(OP_ASSIGN, 0);                // undeclared variable
    send(OP_RESTART, 0);
    send(OP_PUSHVAR, 3);
    send(OP_PUSHINT, 32'h7fff_ffff);
    send(OP_ASSIGN, 0);
    send(OP_PUSHVAR, 3);
    send(OP_PREINC, 0);
    send(OP_PUSHLABEL, 1024);          // jump to the length ends the program
    send(OP_GO, 0);
    send(opcode_e'(5'd31), 32'hffff_ffff);
    send(OP_RESTART, 0);
    send(OP_CLEAR, 0);                 // pop on an empty stack

    // Random phases at several lengths.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_length(0);
        1: write_length(PROG_N);
        2: write_length(1);
        3: write_length($urandom_range(20, 200));
        4: write_length(11'h7ff);
        default: write_length($urandom_range(2, 1024));
      endcase
      send(OP_RESTART, $urandom);
      for (int i = 0; i < 160; i++) begin
        if (ph == 2 && i == 40) begin
          // Long hold-off on the receiver while instructions keep coming.
          fork
            begin
              hold_off = 1;
              repeat (300) @(negedge clk);
              hold_off = 0;
            end
          join_none
        end
        if (ph == 3 && i == 80) drain();
        random_instr();
      end
    end

    drain();
    if (sb.err_count == 0 && sb.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/rsm_pkg.sv
hdl/rsm_alu.sv
hdl/rsm_divider.sv
hdl/rpn_stack_machine_step.sv
hdl/rsm_checker.sv
tb/sv/rpn_stack_machine_step_tb.sv
